FILE: hdl/gzhp_pkg.sv
package gzhp_pkg;

    localparam logic [7:0] MAGIC0     = 8'h1F;
    localparam logic [7:0] MAGIC1     = 8'h8B;
    localparam logic [7:0] MAGIC1_OLD = 8'h9E;

    localparam logic [7:0] FL_CONT  = 8'h02;
    localparam logic [7:0] FL_EXTRA = 8'h04;
    localparam logic [7:0] FL_NAME  = 8'h08;
    localparam logic [7:0] FL_COMM  = 8'h10;
    localparam logic [7:0] FL_CRYPT = 8'h20;
    localparam logic [7:0] FL_RSVD  = 8'hC0;

    typedef enum logic [4:0] {
        PH_MAGIC0    = 5'd0,
        PH_MAGIC1    = 5'd1,
        PH_METHOD    = 5'd2,
        PH_FLAGS     = 5'd3,
        PH_TIME0     = 5'd4,
        PH_TIME1     = 5'd5,
        PH_TIME2     = 5'd6,
        PH_TIME3     = 5'd7,
        PH_XFL       = 5'd8,
        PH_OS        = 5'd9,
        PH_XLEN_LO   = 5'd10,
        PH_XLEN_HI   = 5'd11,
        PH_EXTRA     = 5'd12,
        PH_NAME      = 5'd13,
        PH_COMMENT   = 5'd14,
        PH_PAYLOAD   = 5'd15,
        PH_ERR_MAGIC = 5'd16,
        PH_ERR_CRYPT = 5'd17,
        PH_ERR_MULTI = 5'd18,
        PH_ERR_RSVD  = 5'd19
    } phase_t;

    typedef enum logic [2:0] {
        ST_HDR       = 3'd0,
        ST_DONE      = 3'd1,
        ST_PAYLOAD   = 3'd2,
        ST_BAD_MAGIC = 3'd3,
        ST_ENCRYPTED = 3'd4,
        ST_MULTIPART = 3'd5,
        ST_RESERVED  = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       member_start;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] method;
        logic [7:0] payload_byte;
    } out_item_t;

    // First optional section at or after 'from' that the flags enable, else payload.
    function automatic phase_t next_section(input phase_t from, input logic [7:0] flags);
        phase_t ph;
        ph = PH_PAYLOAD;
        if (from <= PH_COMMENT && (flags & FL_COMM) != 8'h00) begin
            ph = PH_COMMENT;
        end
        if (from <= PH_NAME && (flags & FL_NAME) != 8'h00) begin
            ph = PH_NAME;
        end
        if (from <= PH_XLEN_LO && (flags & FL_EXTRA) != 8'h00) begin
            ph = PH_XLEN_LO;
        end
        return ph;
    endfunction

endpackage

FILE: hdl/gzip_member_header_parser_core.sv
// gzip member header parser, one byte per transfer.
// Input channel s_valid/s_ready/s_item carries data_byte and member_start;
// member_start high makes this byte magic byte 0 of a new member and clears
// the captured flags, method and extra-field count.
// Result channel m_valid/m_ready/m_item returns one result per input byte:
// status (header byte, header done, payload, or a sticky error code), the
// method byte captured so far, and the byte itself when status is payload.
// A byte taken on s_* is registered in the input register, parsed from there,
// and its result is registered in the result register that drives m_*.
// Throughput: one byte per cycle while the receiver takes results; the parse is
// a single step on the phase register between the input and result registers.
// The receiver may stall: the result register holds, the input register
// still fills once, and s_ready drops only when both are occupied.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to expecting magic byte 0 with flags, method and count cleared.
module gzip_member_header_parser_core
    import gzhp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  method_reg, method_next;
    logic [7:0]  first_magic_reg, first_magic_next;
    logic [15:0] extra_reg, extra_next;

    phase_t      ph_cur;
    logic [7:0]  flags_cur;
    logic [7:0]  method_cur;
    logic [15:0] extra_cur;
    logic [15:0] extra_dec;
    logic [7:0]  b;
    status_t     status;
    logic        advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // Restart overrides the stored context for this byte.
    assign b          = in_item_reg.data_byte;
    assign ph_cur     = in_item_reg.member_start ? PH_MAGIC0 : phase_reg;
    assign flags_cur  = in_item_reg.member_start ? 8'h00 : flags_reg;
    assign method_cur = in_item_reg.member_start ? 8'h00 : method_reg;
    assign extra_cur  = in_item_reg.member_start ? 16'h0000 : extra_reg;
    assign extra_dec  = extra_cur - 16'd1;

    // Next state
    always_comb begin
        phase_next       = ph_cur;
        flags_next       = flags_cur;
        method_next      = method_cur;
        first_magic_next = first_magic_reg;
        extra_next       = extra_cur;
        case (ph_cur)
            PH_MAGIC0: begin
                first_magic_next = b;
                phase_next       = PH_MAGIC1;
            end
            PH_MAGIC1: begin
                if (first_magic_reg == MAGIC0 && (b == MAGIC1 || b == MAGIC1_OLD)) begin
                    phase_next = PH_METHOD;
                end else begin
                    phase_next = PH_ERR_MAGIC;
                end
            end
            PH_METHOD: begin
                method_next = b;
                phase_next  = PH_FLAGS;
            end
            PH_FLAGS: begin
                flags_next = b;
                if ((b & FL_CRYPT) != 8'h00) begin
                    phase_next = PH_ERR_CRYPT;
                end else if ((b & FL_CONT) != 8'h00) begin
                    phase_next = PH_ERR_MULTI;
                end else if ((b & FL_RSVD) != 8'h00) begin
                    phase_next = PH_ERR_RSVD;
                end else begin
                    phase_next = PH_TIME0;
                end
            end
            PH_TIME0: phase_next = PH_TIME1;
            PH_TIME1: phase_next = PH_TIME2;
            PH_TIME2: phase_next = PH_TIME3;
            PH_TIME3: phase_next = PH_XFL;
            PH_XFL:   phase_next = PH_OS;
            PH_OS:    phase_next = next_section(PH_XLEN_LO, flags_cur);
            PH_XLEN_LO: begin
                extra_next = {8'h00, b};
                phase_next = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
                extra_next = extra_cur | {b, 8'h00};
                if ((extra_cur | {b, 8'h00}) == 16'h0000) begin
                    phase_next = next_section(PH_NAME, flags_cur);
                end else begin
                    phase_next = PH_EXTRA;
                end
            end
            PH_EXTRA: begin
                extra_next = extra_dec;
                if (extra_dec == 16'h0000) begin
                    phase_next = next_section(PH_NAME, flags_cur);
                end
            end
            PH_NAME: begin
                if (b == 8'h00) begin
                    phase_next = next_section(PH_COMMENT, flags_cur);
                end
            end
            PH_COMMENT: begin
                if (b == 8'h00) begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD, PH_ERR_CRYPT, PH_ERR_MULTI, PH_ERR_RSVD: phase_next = ph_cur;
            default:  phase_next = PH_ERR_MAGIC;
        endcase
    end

    // Outputs
    always_comb begin
        status = ST_HDR;
        case (ph_cur)
            PH_MAGIC1: begin
                if (phase_next == PH_ERR_MAGIC) begin
                    status = ST_BAD_MAGIC;
                end
            end
            PH_FLAGS: begin
                case (phase_next)
                    PH_ERR_CRYPT: status = ST_ENCRYPTED;
                    PH_ERR_MULTI: status = ST_MULTIPART;
                    PH_ERR_RSVD:  status = ST_RESERVED;
                    default:      status = ST_HDR;
                endcase
            end
            PH_OS, PH_XLEN_HI, PH_EXTRA, PH_NAME, PH_COMMENT: begin
                if (phase_next == PH_PAYLOAD) begin
                    status = ST_DONE;
                end
            end
            PH_MAGIC0, PH_METHOD, PH_TIME0, PH_TIME1, PH_TIME2, PH_TIME3,
            PH_XFL, PH_XLEN_LO: status = ST_HDR;
            PH_PAYLOAD:   status = ST_PAYLOAD;
            PH_ERR_CRYPT: status = ST_ENCRYPTED;
            PH_ERR_MULTI: status = ST_MULTIPART;
            PH_ERR_RSVD:  status = ST_RESERVED;
            default:      status = ST_BAD_MAGIC;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_MAGIC0;
            flags_reg       <= 8'h00;
            method_reg      <= 8'h00;
            first_magic_reg <= 8'h00;
            extra_reg       <= 16'h0000;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                phase_reg       <= phase_next;
                flags_reg       <= flags_next;
                method_reg      <= method_next;
                first_magic_reg <= first_magic_next;
                extra_reg       <= extra_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg.status       <= status;
            out_item_reg.method       <= method_next;
            out_item_reg.payload_byte <= (status == ST_PAYLOAD) ? b : 8'h00;
        end
    end

endmodule

FILE: hdl/gzhp_checker.sv
module gzhp_checker
    import gzhp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // Stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Two-entry buffering: a draining receiver never blocks the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != ST_PAYLOAD |-> m_item.payload_byte == 8'h00)
        else $error("payload byte set outside payload");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.status != 3'd7)
        else $error("undefined status code");

endmodule

bind gzip_member_header_parser_core gzhp_checker u_gzhp_checker (.*);

FILE: verif/gzhp_result_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the header parser, predicts one result per input
// transfer and compares each result transfer against the oldest prediction.
module gzhp_result_checker
    import gzhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_item,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_item,
    output int unsigned mismatches,
    output int unsigned pending
);

    localparam int unsigned REPORT_LIMIT = 10;

    // parser state as the block should hold it
    phase_t      hdr_phase;
    logic [7:0]  hdr_flags;
    logic [7:0]  method_seen;
    logic [7:0]  magic_lo;
    logic [15:0] xlen_left;

    out_item_t   expected_results[$];

    function automatic phase_t section_after(input phase_t from, input logic [7:0] fl);
        if (from <= PH_XLEN_LO && (fl & FL_EXTRA) != 8'h00) return PH_XLEN_LO;
        if (from <= PH_NAME && (fl & FL_NAME) != 8'h00) return PH_NAME;
        if (from <= PH_COMMENT && (fl & FL_COMM) != 8'h00) return PH_COMMENT;
        return PH_PAYLOAD;
    endfunction

    function automatic out_item_t parse_byte(input in_item_t it);
        out_item_t  res;
        status_t    st;
        logic [7:0] b;
        b  = it.data_byte;
        st = ST_HDR;
        if (it.member_start) begin
            hdr_flags   = 8'h00;
            method_seen = 8'h00;
            xlen_left   = 16'h0000;
            hdr_phase   = PH_MAGIC0;
        end
        case (hdr_phase)
            PH_MAGIC0: begin
                magic_lo  = b;
                hdr_phase = PH_MAGIC1;
            end
            PH_MAGIC1: begin
                if (magic_lo == MAGIC0 && (b == MAGIC1 || b == MAGIC1_OLD)) begin
                    hdr_phase = PH_METHOD;
                end else begin
                    hdr_phase = PH_ERR_MAGIC;
                    st        = ST_BAD_MAGIC;
                end
            end
            PH_METHOD: begin
                method_seen = b;
                hdr_phase   = PH_FLAGS;
            end
            PH_FLAGS: begin
                hdr_flags = b;
                // encrypted wins over continuation, which wins over reserved
                if ((b & FL_CRYPT) != 8'h00) begin
                    hdr_phase = PH_ERR_CRYPT;
                    st        = ST_ENCRYPTED;
                end else if ((b & FL_CONT) != 8'h00) begin
                    hdr_phase = PH_ERR_MULTI;
                    st        = ST_MULTIPART;
                end else if ((b & FL_RSVD) != 8'h00) begin
                    hdr_phase = PH_ERR_RSVD;
                    st        = ST_RESERVED;
                end else begin
                    hdr_phase = PH_TIME0;
                end
            end
            PH_TIME0, PH_TIME1, PH_TIME2, PH_TIME3, PH_XFL: begin
                hdr_phase = phase_t'(hdr_phase + 5'd1);
            end
            PH_OS: begin
                hdr_phase = section_after(PH_XLEN_LO, hdr_flags);
            end
            PH_XLEN_LO: begin
                xlen_left = {8'h00, b};
                hdr_phase = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
                xlen_left[15:8] = b;
                if (xlen_left == 16'h0000) begin
                    hdr_phase = section_after(PH_NAME, hdr_flags);
                end else begin
                    hdr_phase = PH_EXTRA;
                end
            end
            PH_EXTRA: begin
                xlen_left = xlen_left - 16'd1;
                if (xlen_left == 16'h0000) begin
                    hdr_phase = section_after(PH_NAME, hdr_flags);
                end
            end
            PH_NAME: begin
                if (b == 8'h00) begin
                    hdr_phase = section_after(PH_COMMENT, hdr_flags);
                end
            end
            PH_COMMENT: begin
                if (b == 8'h00) begin
                    hdr_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:   st = ST_PAYLOAD;
            PH_ERR_CRYPT: st = ST_ENCRYPTED;
            PH_ERR_MULTI: st = ST_MULTIPART;
            PH_ERR_RSVD:  st = ST_RESERVED;
            default: begin
                hdr_phase = PH_ERR_MAGIC;
                st        = ST_BAD_MAGIC;
            end
        endcase
        // the byte that lands the parser in payload closes the header
        if (hdr_phase == PH_PAYLOAD && st == ST_HDR) begin
            st = ST_DONE;
        end
        res.status       = st;
        res.method       = method_seen;
        res.payload_byte = (st == ST_PAYLOAD) ? b : 8'h00;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            hdr_phase   = PH_MAGIC0;
            hdr_flags   = 8'h00;
            method_seen = 8'h00;
            magic_lo    = 8'h00;
            xlen_left   = 16'h0000;
            expected_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(parse_byte(s_item));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display({"%0t: result transfer with nothing expected: ",
                                  "status %0d method %h payload %h"},
                                 $time, m_item.status, m_item.method, m_item.payload_byte);
                    end
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.status !== want.status || m_item.method !== want.method ||
                        m_item.payload_byte !== want.payload_byte) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display({"%0t: mismatch: status exp %0d got %0d, ",
                                      "method exp %h got %h, payload exp %h got %h"},
                                     $time, want.status, m_item.status, want.method,
                                     m_item.method, want.payload_byte, m_item.payload_byte);
                        end
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
        pending <= expected_results.size();
    end

endmodule

FILE: verif/gzip_member_header_parser_core_tb.sv
`timescale 1ns / 100ps

module gzip_member_header_parser_core_tb
    import gzhp_pkg::*;
();

    localparam int ITEM_TARGET    = 550;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RX_HOLD_AT     = 150;
    localparam int RX_HOLD_AT2    = 1100;
    localparam int RX_HOLD_LEN    = 80;
    localparam int RX_STEADY_FROM = 500;
    localparam int RX_STEADY_TO   = 800;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    int unsigned mismatches;
    int unsigned pending;
    int          cycle_count = 0;
    int          rx_hold     = 0;
    int          sent        = 0;
    bit          tx_steady   = 1'b0;

    gzip_member_header_parser_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    gzhp_result_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("gzip_member_header_parser_core_tb: errors");
            $finish;
        end
    end

    // receiver: random back-pressure, two long hold-offs, one steady window
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (cycle_count == RX_HOLD_AT || cycle_count == RX_HOLD_AT2) begin
            m_ready <= 1'b0;
            rx_hold <= RX_HOLD_LEN;
        end else if (cycle_count >= RX_STEADY_FROM && cycle_count < RX_STEADY_TO) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 29);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        while (!tx_steady && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= '{data_byte: b, member_start: start};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // mostly well-formed members with random content, the rest broken or noise
    task automatic send_member();
        logic [7:0] flags;
        int         n;
        logic       lead;
        lead = ($urandom_range(99) < 85);
        if ($urandom_range(99) < 80) begin
            send_byte(MAGIC0, lead);
            send_byte($urandom_range(1) ? MAGIC1 : MAGIC1_OLD, 1'b0);
            send_byte(($urandom_range(99) < 70) ? 8'h08 : 8'($urandom_range(255)), 1'b0);
            flags = 8'($urandom_range(255)) & (FL_EXTRA | FL_NAME | FL_COMM | 8'h01);
            send_byte(flags, 1'b0);
            repeat (6) send_byte(8'($urandom_range(255)), 1'b0);
            if ((flags & FL_EXTRA) != 8'h00) begin
                n = ($urandom_range(99) < 75) ? $urandom_range(4) : $urandom_range(40);
                send_byte(8'(n), 1'b0);
                send_byte(8'(n >> 8), 1'b0);
                repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
            end
            if ((flags & FL_NAME) != 8'h00) begin
                repeat ($urandom_range(6)) send_byte(8'($urandom_range(1, 255)), 1'b0);
                send_byte(8'h00, 1'b0);
            end
            if ((flags & FL_COMM) != 8'h00) begin
                repeat ($urandom_range(6)) send_byte(8'($urandom_range(1, 255)), 1'b0);
                send_byte(8'h00, 1'b0);
            end
            repeat ($urandom_range(10)) send_byte(8'($urandom_range(255)), 1'b0);
        end else begin
            case ($urandom_range(3))
                0: begin
                    send_byte($urandom_range(1) ? MAGIC0 : 8'($urandom_range(255)), lead);
                    send_byte(8'($urandom_range(255)), 1'b0);
                    repeat ($urandom_range(4)) send_byte(8'($urandom_range(255)), 1'b0);
                end
                1: begin
                    flags = 8'($urandom_range(255));
                    case ($urandom_range(2))
                        0: flags = flags | FL_CRYPT;
                        1: flags = (flags | FL_CONT) & ~FL_CRYPT;
                        default: flags = (flags & ~(FL_CRYPT | FL_CONT)) |
                                         (8'($urandom_range(1, 3)) << 6);
                    endcase
                    send_byte(MAGIC0, lead);
                    send_byte(MAGIC1, 1'b0);
                    send_byte(8'($urandom_range(255)), 1'b0);
                    send_byte(flags, 1'b0);
                    repeat ($urandom_range(4)) send_byte(8'($urandom_range(255)), 1'b0);
                end
                2: begin
                    // header cut short; the next member restarts it if it leads with member_start
                    send_byte(MAGIC0, lead);
                    send_byte(MAGIC1_OLD, 1'b0);
                    send_byte(8'($urandom_range(255)), 1'b0);
                    send_byte(8'($urandom_range(255)) & (FL_EXTRA | FL_NAME | FL_COMM), 1'b0);
                    repeat ($urandom_range(8)) send_byte(8'($urandom_range(255)), 1'b0);
                end
                default: begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
                    end
                end
            endcase
        end
    endtask

    initial begin
        logic [8:0] directed[$];
        int         m;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed = '{
            // all optional sections, empty extra field, one-char name, empty comment
            {1'b1, MAGIC0}, {1'b0, MAGIC1}, {1'b0, 8'h08},
            {1'b0, FL_EXTRA | FL_NAME | FL_COMM | 8'h01},
            {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'h80}, {1'b0, 8'h7F},
            {1'b0, 8'h00}, {1'b0, 8'hFF},
            {1'b0, 8'h00}, {1'b0, 8'h00},
            {1'b0, 8'h41}, {1'b0, 8'h00},
            {1'b0, 8'h00},
            {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'hA5},
            // restart out of payload, old magic, all error bits: encrypted wins, sticks
            {1'b1, MAGIC0}, {1'b0, MAGIC1_OLD}, {1'b0, 8'hFF},
            {1'b0, FL_CRYPT | FL_CONT | FL_RSVD}, {1'b0, MAGIC1},
            // bad magic, sticky
            {1'b1, MAGIC0}, {1'b0, 8'h8C}, {1'b0, MAGIC0}
        };
        foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

        for (m = 0; sent < ITEM_TARGET; m++) begin
            tx_steady = (m >= 20 && m < 35);
            if (m == 12) begin
                wait_drained();
            end
            send_member();
        end
        tx_steady = 1'b0;

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("gzip_member_header_parser_core_tb: clean");
        end else begin
            $display("gzip_member_header_parser_core_tb: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/gzhp_pkg.sv
hdl/gzip_member_header_parser_core.sv
hdl/gzhp_checker.sv
verif/gzhp_result_checker.sv
verif/gzip_member_header_parser_core_tb.sv
